[rtl/cpm_pkg.sv]
// Shared constants, types and helpers for the closest-pair (Manhattan) block.
package cpm_pkg;

	localparam int unsigned COORD_W        = 16;
	localparam int unsigned DIST_W         = COORD_W + 1;
	localparam int unsigned MAX_POINTS_DEF = 1024;

	localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;

	// One stored point: x in the low half, y in the high half.
	typedef struct packed {
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} point_t;

	localparam int unsigned POINT_W = $bits(point_t);

	function automatic logic [COORD_W-1:0] abs_diff(
		input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b
	);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

[rtl/cpm_in_if.sv]
// Input channel: one point word per handshake.
interface cpm_in_if;
	logic                          valid;
	logic                          ready;
	logic [cpm_pkg::COORD_W-1:0]   x_coord;
	logic [cpm_pkg::COORD_W-1:0]   y_coord;
	logic                          last_point;

	modport source (output valid, output x_coord, output y_coord, output last_point,
		input ready);
	modport sink   (input valid, input x_coord, input y_coord, input last_point,
		output ready);
endinterface

[rtl/cpm_out_if.sv]
// Result channel: one closest-pair word per point set.
interface cpm_out_if;
	logic                          valid;
	logic                          ready;
	logic [cpm_pkg::DIST_W-1:0]    min_distance;
	logic [cpm_pkg::COORD_W-1:0]   first_x;
	logic [cpm_pkg::COORD_W-1:0]   first_y;
	logic [cpm_pkg::COORD_W-1:0]   second_x;
	logic [cpm_pkg::COORD_W-1:0]   second_y;
	logic                          valid_pair;
	logic                          overflowed;

	modport source (output valid, output min_distance, output first_x, output first_y,
		output second_x, output second_y, output valid_pair, output overflowed,
		input ready);
	modport sink   (input valid, input min_distance, input first_x, input first_y,
		input second_x, input second_y, input valid_pair, input overflowed,
		output ready);
endinterface

[rtl/cpm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cpm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/closest_pair_manhattan.sv]
// Top level of the closest-pair finder under Manhattan distance.
//
// Usage:
//   pts : point words (x_coord, y_coord, last_point). While the block is
//         collecting a set, one point is taken per cycle and written to the
//         point RAM. Points beyond MAX_POINTS are dropped and noted.
//   res : one result word per set, issued after the word with last_point.
//
// Search, for n stored points:
//   The search reads the RAM once per pair through its single read port,
//   plus once per outer point, and compares the pairs one by one. With n < 2
//   the search is skipped and the block goes straight to the finish step.
//   pts.ready is low for the whole search; the shared |dx|+|dy| unit and
//   the read port set the pace.
//
// Reset clears the point count, the drop flag, the best distance and the
// result valid flag; RAM contents are not cleared (only entries of the
// current set are read). If the receiver stalls, the result is held in the
// output register; the next set may load meanwhile, and its own result
// waits until the previous one has been taken.
module closest_pair_manhattan #(
	parameter int unsigned MAX_POINTS = cpm_pkg::MAX_POINTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cpm_in_if.sink     pts,
	cpm_out_if.source  res
);

	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam int unsigned CW = $clog2(MAX_POINTS + 1);
	localparam int unsigned CW_ = cpm_pkg::COORD_W;
	localparam int unsigned DW = cpm_pkg::DIST_W;

	typedef enum logic [5:0] {
		ST_LOAD   = 6'b000001,   // collecting points
		ST_RDI    = 6'b000010,   // read outer point i
		ST_LATCH  = 6'b000100,   // capture point i
		ST_SCAN   = 6'b001000,   // stream inner points j > i
		ST_DRAIN  = 6'b010000,   // let the distance pipe empty
		ST_FINISH = 6'b100000    // hand result to output register
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic                   drop_q;
	logic                   pair_q;
	logic [AW-1:0]          i_q;
	logic [AW-1:0]          j_q;
	logic [AW-1:0]          last_q;
	cpm_pkg::point_t        pi_q;

	// distance pipe
	logic                   rvld_s1;
	logic                   v_s2;
	logic [CW_-1:0]         dx_s2;
	logic [CW_-1:0]         dy_s2;
	cpm_pkg::point_t        p_s2;
	cpm_pkg::point_t        q_s2;
	logic [DW-1:0]          dist_s2;

	logic [DW-1:0]          best_q;
	cpm_pkg::point_t        bfirst_q;
	cpm_pkg::point_t        bsecond_q;

	// result register
	logic                   out_vld_q;
	logic [DW-1:0]          o_dist_q;
	cpm_pkg::point_t        o_first_q;
	cpm_pkg::point_t        o_second_q;
	logic                   o_pair_q;
	logic                   o_ovf_q;

	logic                   accept;
	logic                   store_ok;
	logic [CW-1:0]          n_new;
	logic                   has_pair;
	logic                   out_load;
	logic                   better;
	cpm_pkg::point_t        wpt;
	cpm_pkg::point_t        rpt;
	logic [AW-1:0]          raddr;

	assign pts.ready = (state_q == ST_LOAD);
	assign accept    = pts.valid & pts.ready;
	assign store_ok  = (count_q != CW'(MAX_POINTS));
	assign n_new     = count_q + CW'(store_ok);
	assign has_pair  = (n_new >= CW'(2));
	assign out_load  = (state_q == ST_FINISH) && (!out_vld_q || res.ready);

	assign wpt.x = pts.x_coord;
	assign wpt.y = pts.y_coord;
	assign raddr = (state_q == ST_RDI) ? i_q : j_q;

	cpm_ram #(
		.WIDTH (cpm_pkg::POINT_W),
		.DEPTH (MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (accept && store_ok),
		.waddr (count_q[AW-1:0]),
		.wdata (wpt),
		.raddr (raddr),
		.rdata (rpt)
	);

	// Shared distance unit: stage 1 takes |dx| and |dy| of the RAM word against
	// point i, stage 2 sums them and compares with the best so far.
	assign dist_s2 = {1'b0, dx_s2} + {1'b0, dy_s2};
	assign better  = v_s2 && (dist_s2 < best_q);

	always_ff @(posedge clk) begin
		dx_s2 <= cpm_pkg::abs_diff(pi_q.x, rpt.x);
		dy_s2 <= cpm_pkg::abs_diff(pi_q.y, rpt.y);
		p_s2  <= pi_q;
		q_s2  <= rpt;
		if (state_q == ST_LATCH) begin
			pi_q <= rpt;
		end
		if (better) begin
			bfirst_q  <= p_s2;
			bsecond_q <= q_s2;
		end
		if (out_load) begin
			o_dist_q   <= pair_q ? best_q : '0;
			o_first_q  <= pair_q ? bfirst_q : '0;
			o_second_q <= pair_q ? bsecond_q : '0;
			o_pair_q   <= pair_q;
			o_ovf_q    <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			drop_q    <= 1'b0;
			pair_q    <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			last_q    <= '0;
			rvld_s1   <= 1'b0;
			v_s2      <= 1'b0;
			best_q    <= cpm_pkg::DIST_ALL_ONES;
			out_vld_q <= 1'b0;
		end else begin
			rvld_s1 <= (state_q == ST_SCAN);
			v_s2    <= rvld_s1;
			if (better) begin
				best_q <= dist_s2;
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						count_q <= n_new;
						if (!store_ok) begin
							drop_q <= 1'b1;
						end
						if (pts.last_point) begin
							pair_q  <= has_pair;
							last_q  <= AW'(n_new - CW'(1));
							i_q     <= '0;
							state_q <= has_pair ? ST_RDI : ST_FINISH;
						end
					end
				end
				ST_RDI: begin
					state_q <= ST_LATCH;
				end
				ST_LATCH: begin
					j_q     <= AW'(i_q + 1'b1);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (j_q == last_q) begin
						if (AW'(i_q + 1'b1) == last_q) begin
							state_q <= ST_DRAIN;
						end else begin
							i_q     <= AW'(i_q + 1'b1);
							state_q <= ST_RDI;
						end
					end else begin
						j_q <= AW'(j_q + 1'b1);
					end
				end
				ST_DRAIN: begin
					if (!rvld_s1 && !v_s2) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						count_q <= '0;
						drop_q  <= 1'b0;
						best_q  <= cpm_pkg::DIST_ALL_ONES;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign res.valid        = out_vld_q;
	assign res.min_distance = o_dist_q;
	assign res.first_x      = o_first_q.x;
	assign res.first_y      = o_first_q.y;
	assign res.second_x     = o_second_q.x;
	assign res.second_y     = o_second_q.y;
	assign res.valid_pair   = o_pair_q;
	assign res.overflowed   = o_ovf_q;

	// A new result word only comes from the finish step.
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_FINISH))
		else $error("result word raised outside finish step");

	// The point count never passes the store size.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count beyond capacity");

	// Inner index stays strictly after the outer one and within the set.
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (j_q > i_q) && (j_q <= last_q))
		else $error("scan index out of order");

	// A set without a pair reports a zero distance.
	a_nopair_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !o_pair_q) |-> (o_dist_q == '0))
		else $error("nonzero distance without a pair");

endmodule
